// ===== hdl/cbc_pkg.sv =====
// ---------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cartridge bank controller: item kinds,
// bus address regions, read source codes and default sizes.
// ---------------------------------------------------------------------------
package cbc_pkg;

    // default store sizes
    localparam int ROM_BANKS_DEF = 128;
    localparam int RAM_BYTES_DEF = 32768;

    // fixed bank geometry
    localparam int BANK_BYTES     = 16384;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int BANK_OFS_W     = 14;
    localparam int RAM_OFS_W      = 13;
    localparam int BANK_NUM_W     = 7;
    localparam int BANK_NUM_CNT   = 128;
    localparam int BANK_LOW_W     = 5;
    localparam int BANK_HIGH_W    = 2;
    localparam int RAM_BANK_CNT   = 4;

    // payload widths
    localparam int ADDR_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int LOAD_ADDR_W = 21;

    // output queue depth (also bounds the reads in flight)
    localparam int Q_DEPTH = 4;

    // register write values
    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    // item kinds carried on tuser
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_LOAD  = 2'd2
    } kind_t;

    // 8 KiB bus regions, address bits 15:13
    localparam logic [2:0] RGN_RAM_EN = 3'd0;
    localparam logic [2:0] RGN_BANK_L = 3'd1;
    localparam logic [2:0] RGN_BANK_H = 3'd2;
    localparam logic [2:0] RGN_MODE   = 3'd3;
    localparam logic [2:0] RGN_EXTRAM = 3'd5;

    // where a read beat takes its byte from
    typedef enum logic [1:0] {
        SRC_ROM  = 2'd0,
        SRC_RAM  = 2'd1,
        SRC_OPEN = 2'd2
    } src_t;

    // read request handed from the decoder to the response path
    typedef struct packed {
        logic valid;
        src_t src;
    } rd_ctrl_t;

endpackage

// ===== hdl/cbc_ram.sv =====
// ---------------------------------------------------------------------------
// cbc_ram
// Generic single-port synchronous RAM with one write or read per cycle and
// a registered read port.
// ---------------------------------------------------------------------------
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cbc_ctrl.sv =====
// ---------------------------------------------------------------------------
// cbc_ctrl
// Banking registers and address decode: updates the control registers on
// bus writes and turns each accepted beat into ROM and RAM port accesses.
// ---------------------------------------------------------------------------
module cbc_ctrl #(
    parameter int ROM_BANKS = cbc_pkg::ROM_BANKS_DEF,
    parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEF,
    localparam int ROM_AW   = $clog2(ROM_BANKS) + cbc_pkg::BANK_OFS_W,
    localparam int RAM_AW   = $clog2(RAM_BYTES)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             acc,
    input  logic [1:0]                       kind,
    input  logic [cbc_pkg::ADDR_W-1:0]       address,
    input  logic [cbc_pkg::BYTE_W-1:0]       data,
    input  logic [cbc_pkg::LOAD_ADDR_W-1:0]  load_address,
    output logic                             rom_we,
    output logic [ROM_AW-1:0]                rom_addr,
    output logic                             ram_we,
    output logic [RAM_AW-1:0]                ram_addr,
    output cbc_pkg::rd_ctrl_t                rd_ctrl
);

    localparam int BW        = $clog2(ROM_BANKS);
    localparam int ROM_BYTES = ROM_BANKS * cbc_pkg::BANK_BYTES;
    localparam int LA_CMP_W  = cbc_pkg::LOAD_ADDR_W + 1;
    localparam int SUM_W     = 16;
    localparam int MOD_STEPS = 4;

    logic                             ram_en_reg, ram_en_next;
    logic [cbc_pkg::BANK_LOW_W-1:0]   bank_low_reg, bank_low_next;
    logic [cbc_pkg::BANK_HIGH_W-1:0]  bank_high_reg, bank_high_next;
    logic                             mode_reg, mode_next;

    logic [BW-1:0]                    bank_wrap [cbc_pkg::BANK_NUM_CNT];
    logic [SUM_W-1:0]                 ram_base  [cbc_pkg::RAM_BANK_CNT];
    logic [cbc_pkg::BANK_LOW_W-1:0]   low_eff;
    logic [cbc_pkg::BANK_NUM_W-1:0]   rom_bank;
    logic [cbc_pkg::BANK_HIGH_W-1:0]  ram_bank;
    logic [SUM_W-1:0]                 ram_idx;
    logic [2:0]                       region;
    logic                             load_ok;
    cbc_pkg::kind_t                   kind_c;

    // bank number wrap and ram bank base offsets, folded at elaboration
    for (genvar g = 0; g < cbc_pkg::BANK_NUM_CNT; g++) begin : g_wrap
        assign bank_wrap[g] = BW'(g % ROM_BANKS);
    end
    for (genvar g = 0; g < cbc_pkg::RAM_BANK_CNT; g++) begin : g_base
        assign ram_base[g] = SUM_W'((g * cbc_pkg::RAM_BANK_BYTES) % RAM_BYTES);
    end

    assign kind_c = cbc_pkg::kind_t'(kind);
    assign region = address[15:13];

    // rom bank select, low bank of zero reads as one
    assign low_eff  = (bank_low_reg == '0) ? cbc_pkg::BANK_LOW_W'(1) : bank_low_reg;
    always_comb begin
        if (address[14]) begin
            rom_bank = {bank_high_reg, low_eff};
        end else if (mode_reg) begin
            rom_bank = {bank_high_reg, cbc_pkg::BANK_LOW_W'(0)};
        end else begin
            rom_bank = '0;
        end
    end

    // ram index: base plus offset, then wrap into the ram by up to four subtracts
    assign ram_bank = mode_reg ? bank_high_reg : '0;
    always_comb begin
        logic [SUM_W-1:0] v;
        v = ram_base[ram_bank] + SUM_W'(address[cbc_pkg::RAM_OFS_W-1:0]);
        for (int i = 0; i < MOD_STEPS; i++) begin
            if (v >= SUM_W'(RAM_BYTES)) begin
                v = v - SUM_W'(RAM_BYTES);
            end
        end
        ram_idx = v;
    end
    assign ram_addr = ram_idx[RAM_AW-1:0];

    // rom port shared by image loads and bus reads
    assign load_ok  = {1'b0, load_address} < LA_CMP_W'(ROM_BYTES);
    assign rom_addr = (kind_c == cbc_pkg::KIND_LOAD) ? load_address[ROM_AW-1:0]
                                                     : {bank_wrap[rom_bank],
                                                        address[cbc_pkg::BANK_OFS_W-1:0]};

    // per-beat actions
    always_comb begin
        rom_we         = 1'b0;
        ram_we         = 1'b0;
        rd_ctrl.valid  = 1'b0;
        rd_ctrl.src    = cbc_pkg::SRC_OPEN;
        ram_en_next    = ram_en_reg;
        bank_low_next  = bank_low_reg;
        bank_high_next = bank_high_reg;
        mode_next      = mode_reg;
        if (acc) begin
            unique case (kind_c)
                cbc_pkg::KIND_READ: begin
                    rd_ctrl.valid = 1'b1;
                    if (!address[15]) begin
                        rd_ctrl.src = cbc_pkg::SRC_ROM;
                    end else if (region == cbc_pkg::RGN_EXTRAM && ram_en_reg) begin
                        rd_ctrl.src = cbc_pkg::SRC_RAM;
                    end
                end
                cbc_pkg::KIND_WRITE: begin
                    unique case (region)
                        cbc_pkg::RGN_RAM_EN: ram_en_next = (data[3:0] == cbc_pkg::RAM_EN_KEY);
                        cbc_pkg::RGN_BANK_L: bank_low_next = data[cbc_pkg::BANK_LOW_W-1:0];
                        cbc_pkg::RGN_BANK_H: bank_high_next = data[cbc_pkg::BANK_HIGH_W-1:0];
                        cbc_pkg::RGN_MODE:   mode_next = data[0];
                        cbc_pkg::RGN_EXTRAM: ram_we = ram_en_reg;
                        default: ;
                    endcase
                end
                cbc_pkg::KIND_LOAD: begin
                    rom_we = load_ok;
                end
                default: ;
            endcase
        end
    end

    // banking registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_en_reg    <= 1'b0;
            bank_low_reg  <= cbc_pkg::BANK_LOW_W'(1);
            bank_high_reg <= '0;
            mode_reg      <= 1'b0;
        end else begin
            ram_en_reg    <= ram_en_next;
            bank_low_reg  <= bank_low_next;
            bank_high_reg <= bank_high_next;
            mode_reg      <= mode_next;
        end
    end

`ifndef SYNTHESIS
    // a ram write only ever happens with the ram enabled
    a_ram_we_en: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ram_en_reg)
        else $error("ram write while ram disabled");

    // a read beat never drives a memory write
    a_rd_no_we: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_ctrl.valid |-> !(rom_we || ram_we))
        else $error("read beat wrote a store");

    // the wrapped ram index always lands inside the ram
    a_ram_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |-> ram_idx < SUM_W'(RAM_BYTES))
        else $error("ram index out of range");
`endif

endmodule

// ===== hdl/cbc_resp_q.sv =====
// ---------------------------------------------------------------------------
// cbc_resp_q
// Small result queue in flip-flops that decouples the read pipeline from a
// stalling master side.
// ---------------------------------------------------------------------------
module cbc_resp_q #(
    parameter int DEPTH = cbc_pkg::Q_DEPTH,
    localparam int LW   = $clog2(DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [cbc_pkg::BYTE_W-1:0] push_data,
    output logic [LW-1:0]              level,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cbc_pkg::BYTE_W-1:0] m_tdata
);

    localparam int PW = $clog2(DEPTH);

    logic [cbc_pkg::BYTE_W-1:0] data_reg [DEPTH];
    logic [PW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]              cnt_reg, cnt_next;
    logic                       pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = data_reg[rd_ptr_reg];
    assign level    = cnt_reg;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + LW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    // no push into a full queue that is not draining
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == LW'(DEPTH)) |-> (!push || pop))
        else $error("result queue overflow");

    // fill count stays within depth
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LW'(DEPTH))
        else $error("result queue count out of range");
`endif

endmodule

// ===== hdl/cartridge_bank_controller.sv =====
// ---------------------------------------------------------------------------
// cartridge_bank_controller
// Banked cartridge controller: ROM image loading, banking registers, banked
// ROM and RAM reads and writes on a streaming bus interface.
// ---------------------------------------------------------------------------
// Every beat on the slave side is a bus read, a bus write or one ROM image
// byte load, chosen by s_tuser. Only reads return a beat on the master side,
// in order, one byte each. A beat is taken every cycle while fewer than four
// reads are in flight or waiting in the result queue; a read's byte goes
// through the registered read port of the ROM and RAM memories and then
// the result queue before it leaves. Register and store writes act on the
// next beat. The stores are not cleared at reset: reading a location that
// was never written returns an unspecified byte.
// ---------------------------------------------------------------------------
module cartridge_bank_controller #(
    parameter int ROM_BANKS = cbc_pkg::ROM_BANKS_DEF,
    parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // address[15:0], data[23:16], load_address[44:24], zero
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // read_data[7:0]
);

    localparam int ROM_AW = $clog2(ROM_BANKS) + cbc_pkg::BANK_OFS_W;
    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int LW     = $clog2(cbc_pkg::Q_DEPTH + 1);

    logic                       s_acc;
    logic                       rom_we, ram_we;
    logic [ROM_AW-1:0]          rom_addr;
    logic [RAM_AW-1:0]          ram_addr;
    logic [cbc_pkg::BYTE_W-1:0] rom_q, ram_q, rd_byte;
    logic [cbc_pkg::BYTE_W-1:0] wr_byte;
    cbc_pkg::rd_ctrl_t          rd_ctrl;
    logic                       rd_pend_reg;
    cbc_pkg::src_t              rd_src_reg;
    logic [LW-1:0]              q_level;

    assign s_acc   = s_tvalid && s_tready;
    assign wr_byte = s_tdata[23:16];

    // accept while the queue has room for every read in flight
    assign s_tready = ({1'b0, q_level} + (LW + 1)'(rd_pend_reg)) < (LW + 1)'(cbc_pkg::Q_DEPTH);

    // banking registers and address decode
    cbc_ctrl #(
        .ROM_BANKS (ROM_BANKS),
        .RAM_BYTES (RAM_BYTES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .acc          (s_acc),
        .kind         (s_tuser),
        .address      (s_tdata[15:0]),
        .data         (wr_byte),
        .load_address (s_tdata[44:24]),
        .rom_we       (rom_we),
        .rom_addr     (rom_addr),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .rd_ctrl      (rd_ctrl)
    );

    // rom image store
    cbc_ram #(
        .WIDTH (cbc_pkg::BYTE_W),
        .DEPTH (ROM_BANKS * cbc_pkg::BANK_BYTES)
    ) u_rom (
        .aclk  (aclk),
        .we    (rom_we),
        .addr  (rom_addr),
        .wdata (wr_byte),
        .rdata (rom_q)
    );

    // cartridge ram store
    cbc_ram #(
        .WIDTH (cbc_pkg::BYTE_W),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr_byte),
        .rdata (ram_q)
    );

    // read stage matching the memory latency
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= rd_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        rd_src_reg <= rd_ctrl.src;
    end

    // pick the returned byte
    always_comb begin
        unique case (rd_src_reg)
            cbc_pkg::SRC_ROM: rd_byte = rom_q;
            cbc_pkg::SRC_RAM: rd_byte = ram_q;
            default:          rd_byte = cbc_pkg::OPEN_BUS;
        endcase
    end

    // result queue towards the master side
    cbc_resp_q #(
        .DEPTH (cbc_pkg::Q_DEPTH)
    ) u_resp_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rd_pend_reg),
        .push_data (rd_byte),
        .level     (q_level),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    // an accepted read beat is in the read stage in the next cycle
    a_rd_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == cbc_pkg::KIND_READ) |=> rd_pend_reg)
        else $error("read beat lost before the read stage");

    // only read beats reach the read stage
    a_rd_only: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(s_acc && s_tuser == cbc_pkg::KIND_READ))
        else $error("read stage filled without a read beat");

    // reads in flight never exceed the queue room
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, q_level} + (LW + 1)'(rd_pend_reg)) <= (LW + 1)'(cbc_pkg::Q_DEPTH))
        else $error("more reads in flight than queue room");
`endif

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the cartridge bank controller. Drives bus reads,
// bus writes, ROM image loads and spare kinds on the slave stream. It
// predicts every read byte from a mirror of the banking registers and of the
// ROM and RAM contents, and checks each master beat in order. Reads only
// touch store bytes that were written before them.
// ---------------------------------------------------------------------------
module testbench;

    localparam int          ROM_SIZE   = cbc_pkg::ROM_BANKS_DEF * cbc_pkg::BANK_BYTES;
    localparam int          ITEM_GOAL  = 1450;
    localparam int          PAUSE_STEP = 400;
    localparam int          IDLE_LIMIT = 1000;
    localparam int          TAIL_WAIT  = 20;
    localparam logic [1:0]  KIND_SPARE = 2'd3;

    localparam logic [15:0] CORNER_ADDRS [10] = '{
        16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000,
        16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000, 16'hFFFF
    };

    // receiver stall styles
    typedef enum logic [1:0] {
        RX_FREE   = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_LONG   = 2'd3
    } rx_style_t;

    // mirror of the controller: banking registers, stores, pending read bytes
    class bank_scoreboard;
        logic       ram_en;
        logic [4:0] bank_lo;
        logic [1:0] bank_hi;
        logic       mode;
        logic [7:0] rom_img [int];
        logic [7:0] ram_img [int];
        logic [7:0] expected_bytes [$];
        int         errors;

        function new();
            ram_en  = 1'b0;
            bank_lo = 5'd1;
            bank_hi = 2'd0;
            mode    = 1'b0;
            errors  = 0;
        endfunction

        // physical rom byte behind a bus address below 0x8000
        function int rom_slot(logic [15:0] addr);
            int bank;
            if (addr[14])
                bank = {bank_hi, (bank_lo == 5'd0) ? 5'd1 : bank_lo};
            else
                bank = mode ? {bank_hi, 5'd0} : 0;
            return (bank % cbc_pkg::ROM_BANKS_DEF) * cbc_pkg::BANK_BYTES + int'(addr[13:0]);
        endfunction

        // physical ram byte behind a bus address in the external ram window
        function int ram_slot(logic [15:0] addr);
            int rb;
            rb = mode ? int'(bank_hi) : 0;
            return (rb * cbc_pkg::RAM_BANK_BYTES + int'(addr[12:0])) % cbc_pkg::RAM_BYTES_DEF;
        endfunction

        function logic [7:0] predict_read(logic [15:0] addr);
            int slot;
            if (!addr[15]) begin
                slot = rom_slot(addr);
                return rom_img.exists(slot) ? rom_img[slot] : 8'h00;
            end
            if (addr[15:13] == cbc_pkg::RGN_EXTRAM && ram_en) begin
                slot = ram_slot(addr);
                return ram_img.exists(slot) ? ram_img[slot] : 8'h00;
            end
            return cbc_pkg::OPEN_BUS;
        endfunction

        // accepted slave beat
        function void note_beat(logic [1:0] kind, logic [15:0] addr, logic [7:0] value,
                                logic [20:0] ladr);
            case (kind)
                cbc_pkg::KIND_READ: expected_bytes.push_back(predict_read(addr));
                cbc_pkg::KIND_WRITE: begin
                    case (addr[15:13])
                        cbc_pkg::RGN_RAM_EN: ram_en  = (value[3:0] == cbc_pkg::RAM_EN_KEY);
                        cbc_pkg::RGN_BANK_L: bank_lo = value[4:0];
                        cbc_pkg::RGN_BANK_H: bank_hi = value[1:0];
                        cbc_pkg::RGN_MODE:   mode    = value[0];
                        cbc_pkg::RGN_EXTRAM: if (ram_en) ram_img[ram_slot(addr)] = value;
                        default: ;
                    endcase
                end
                cbc_pkg::KIND_LOAD: if (int'(ladr) < ROM_SIZE) rom_img[int'(ladr)] = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // accepted master beat
        task check_byte(logic [7:0] got);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("read_data 0x%02h with no read waiting", got));
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    report($sformatf("read_data 0x%02h, expected 0x%02h", got, want));
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // address[15:0], data[23:16], load_address[44:24], zero
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // read_data[7:0]

    bank_scoreboard board = new();
    int             items_sent = 0;
    int             burst_left = 0;
    int             idle_cycles = 0;
    rx_style_t      rx_style = RX_FREE;
    int             rx_left = 0;

    cartridge_bank_controller dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #6 aclk = ~aclk;

    // beat monitor and idle watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_beat(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[44:24]);
            if (m_tvalid && m_tready)
                board.check_byte(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("FAIL cartridge_bank_controller");
                $finish;
            end
        end
    end

    // receiver stalls in styles that are picked at random in turn
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_style = rx_style_t'($urandom_range(0, 3));
            rx_left  = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        case (rx_style)
            RX_FREE:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= ((rx_left % 24) >= 18);
        endcase
    end

    // one slave beat; returns after acceptance, and after the gap when a burst ends
    task automatic put_beat(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] value, input logic [20:0] ladr);
        s_tuser  <= kind;
        s_tdata  <= {3'b000, ladr, value, addr};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
        if (kind != KIND_SPARE)
            items_sent++;
        // burst over: gap before the next beat
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_at(input logic [15:0] addr, input logic [7:0] value);
        put_beat(cbc_pkg::KIND_WRITE, addr, value, 21'($urandom));
    endtask

    task automatic load_at(input logic [20:0] ladr, input logic [7:0] value);
        put_beat(cbc_pkg::KIND_LOAD, 16'($urandom), value, ladr);
    endtask

    // read, preceded by a fill of the target byte when it was never written
    task automatic read_at(input logic [15:0] addr);
        int slot;
        if (!addr[15]) begin
            slot = board.rom_slot(addr);
            if (!board.rom_img.exists(slot))
                load_at(21'(slot), 8'($urandom));
        end else if (addr[15:13] == cbc_pkg::RGN_EXTRAM && board.ram_en) begin
            slot = board.ram_slot(addr);
            if (!board.ram_img.exists(slot))
                write_at(addr, 8'($urandom));
        end
        put_beat(cbc_pkg::KIND_READ, addr, 8'($urandom), 21'($urandom));
    endtask

    // hold the sender until every read byte has come back
    task automatic drain_reads();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (board.pending() != 0);
    endtask

    function automatic logic [15:0] pick_read_addr();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(16'h0000, 16'h3FFF));
            2:       return 16'($urandom_range(16'h4000, 16'h7FFF));
            3, 4:    return 16'($urandom_range(16'hA000, 16'hBFFF));
            default: return CORNER_ADDRS[$urandom_range(0, 9)];
        endcase
    endfunction

    // stimulus
    initial begin
        logic [2:0]  rgn;
        logic [7:0]  value;
        logic [15:0] addr;
        int          next_pause;
        int          pick;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = cbc_pkg::KIND_READ;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: low bank zero selects bank one, window corners
        write_at(16'h2000, 8'h00);
        read_at(16'h4000);
        read_at(16'h7FFF);
        read_at(16'h0000);
        read_at(16'h3FFF);
        // ram disabled, then enabled by the key in the low nibble only
        read_at(16'hA000);
        write_at(16'h1FFF, 8'h1A);
        write_at(16'hBFFF, 8'h5C);
        read_at(16'hBFFF);
        // high bank and mode 1: banked low window and ram bank 3
        write_at(16'h5FFF, 8'hFF);
        write_at(16'h7FFF, 8'hFF);
        read_at(16'h0000);
        read_at(16'hA000);
        write_at(16'h0000, 8'h00);
        read_at(16'hBFFF);
        // outside the cartridge ranges
        read_at(16'h8000);
        read_at(16'h9FFF);
        read_at(16'hC000);
        read_at(16'hFFFF);
        put_beat(KIND_SPARE, 16'hFFFF, 8'hFF, 21'h1FFFFF);
        // top rom byte through the top bank
        load_at(21'h1FFFFF, 8'hFF);
        write_at(16'h2000, 8'hFF);
        read_at(16'h7FFF);
        write_at(16'h6000, 8'h00);
        write_at(16'h4000, 8'h00);
        drain_reads();

        // random traffic, mostly well-formed accesses
        next_pause = items_sent + PAUSE_STEP;
        while (items_sent < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                read_at(pick_read_addr());
            end else if (pick < 60) begin
                rgn   = 3'($urandom_range(cbc_pkg::RGN_RAM_EN, cbc_pkg::RGN_MODE));
                value = 8'($urandom);
                if (rgn == cbc_pkg::RGN_RAM_EN && $urandom_range(0, 1))
                    value[3:0] = cbc_pkg::RAM_EN_KEY;
                write_at({rgn, 13'($urandom)}, value);
            end else if (pick < 75) begin
                write_at({cbc_pkg::RGN_EXTRAM, 13'($urandom)}, 8'($urandom));
            end else if (pick < 92) begin
                if ($urandom_range(0, 1))
                    load_at(21'($urandom), 8'($urandom));
                else
                    load_at(21'(board.rom_slot(16'($urandom_range(0, 16'h7FFF)))),
                            8'($urandom));
            end else if (pick < 96) begin
                put_beat(KIND_SPARE, 16'($urandom), 8'($urandom), 21'($urandom));
            end else begin
                // writes that hit no register and no store
                addr = $urandom_range(0, 1) ? 16'($urandom_range(16'h8000, 16'h9FFF))
                                            : 16'($urandom_range(16'hC000, 16'hFFFF));
                write_at(addr, 8'($urandom));
            end
            if (items_sent >= next_pause) begin
                drain_reads();
                next_pause = items_sent + PAUSE_STEP;
            end
        end

        // wind down
        drain_reads();
        repeat (TAIL_WAIT) @(negedge aclk);
        if (board.errors == 0)
            $display("PASS cartridge_bank_controller");
        else
            $display("FAIL cartridge_bank_controller");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cbc_pkg.sv
hdl/cbc_ram.sv
hdl/cbc_ctrl.sv
hdl/cbc_resp_q.sv
hdl/cartridge_bank_controller.sv
verif/testbench.sv
